### sv/sensor_frame_crc_parser_macros.svh
// ----------------------------------------------------------------------------
// Sensor frame CRC parser assertion macros
// Concurrent assertion wrappers, empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef SENSOR_FRAME_CRC_PARSER_MACROS_SVH
`define SENSOR_FRAME_CRC_PARSER_MACROS_SVH

`ifndef SYNTHESIS

`define SFCP_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sfcp assertion failed");

`define SFCP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sfcp assertion failed");

`else

`define SFCP_ASSERT_NOW(lbl, clk, rst, ante, cons)

`define SFCP_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

### sv/sfcp_pkg.sv
// ----------------------------------------------------------------------------
// sfcp_pkg
// Shared types, constants, the CRC-8 byte step and word cleaning for the frame parser.
// ----------------------------------------------------------------------------
package sfcp_pkg;

  localparam int unsigned NUM_WORDS = 9;
  localparam int unsigned LAST_WORD = NUM_WORDS - 1;
  localparam int unsigned FIRST_SIGNED_WORD = 4;
  localparam int unsigned LAST_SIGNED_WORD = 7;

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [15:0] UNSIGNED_INVALID = 16'hFFFF;
  localparam logic [15:0] SIGNED_INVALID = 16'h7FFF;

  localparam logic [1:0] PHASE_HIGH = 2'd0;
  localparam logic [1:0] PHASE_LOW = 2'd1;
  localparam logic [1:0] PHASE_CRC = 2'd2;

  typedef logic [3:0] word_idx_t;
  typedef logic [NUM_WORDS-1:0][15:0] words_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] rx_byte;
    logic       frame_start;
  } item_t;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic [15:0] clean_word(input int unsigned idx, input logic [15:0] w);
    logic [15:0] marker;
    marker = (idx >= FIRST_SIGNED_WORD && idx <= LAST_SIGNED_WORD) ?
             SIGNED_INVALID : UNSIGNED_INVALID;
    return (w == marker) ? 16'h0000 : w;
  endfunction

endpackage

### sv/sfcp_in_stage.sv
// ----------------------------------------------------------------------------
// sfcp_in_stage
// Input register for received bytes; refills in the cycle it is drained.
// ----------------------------------------------------------------------------
module sfcp_in_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    rx_byte,
  input  logic          frame_start,
  input  logic          take,
  output sfcp_pkg::item_t item
);
  import sfcp_pkg::*;

  assign in_ready = !item.valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item.valid <= 1'b0;
    end else if (in_ready) begin
      item.valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      item.rx_byte     <= rx_byte;
      item.frame_start <= frame_start;
    end
  end

endmodule

### sv/sfcp_core.sv
// ----------------------------------------------------------------------------
// sfcp_core
// Byte position tracking, word CRC check, word staging and commit, and the
// result register.
// ----------------------------------------------------------------------------
module sfcp_core (
  input  logic            clk,
  input  logic            rst,
  input  sfcp_pkg::item_t item,
  output logic            take,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            crc_ok,
  output sfcp_pkg::words_t committed
);
  import sfcp_pkg::*;
  `include "sensor_frame_crc_parser_macros.svh"

  logic [1:0] phase;
  word_idx_t  word;
  logic [7:0] running_crc;
  logic [7:0] high_byte_hold;
  logic       frame_good;
  logic [15:0] staged [NUM_WORDS];

  logic [1:0] cur_phase;
  word_idx_t  cur_word;
  logic       cur_good;
  logic       good_now;
  logic       last;

  always_comb begin
    cur_phase = item.frame_start ? PHASE_HIGH : phase;
    cur_word  = item.frame_start ? '0 : word;
    cur_good  = item.frame_start ? 1'b1 : frame_good;
    good_now  = cur_good && (running_crc == item.rx_byte);
    last      = (cur_phase == PHASE_CRC) && (cur_word == word_idx_t'(LAST_WORD));
    take      = item.valid && (!last || !out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PHASE_HIGH;
      word        <= '0;
      running_crc <= CRC_INIT;
      frame_good  <= 1'b1;
      out_valid   <= 1'b0;
      crc_ok      <= 1'b0;
      committed   <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (take) begin
        case (cur_phase)
          PHASE_HIGH: begin
            running_crc <= crc8_step(CRC_INIT, item.rx_byte);
            frame_good  <= cur_good;
            phase       <= PHASE_LOW;
            word        <= cur_word;
          end
          PHASE_LOW: begin
            running_crc <= crc8_step(running_crc, item.rx_byte);
            frame_good  <= cur_good;
            phase       <= PHASE_CRC;
            word        <= cur_word;
          end
          default: begin
            running_crc <= CRC_INIT;
            phase       <= PHASE_HIGH;
            if (last) begin
              word       <= '0;
              frame_good <= 1'b1;
              out_valid  <= 1'b1;
              crc_ok     <= good_now;
              if (good_now) begin
                for (int k = 0; k < NUM_WORDS; k++) begin
                  committed[k] <= clean_word(k, staged[k]);
                end
              end
            end else begin
              word       <= cur_word + word_idx_t'(1);
              frame_good <= good_now;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && cur_phase == PHASE_HIGH) begin
      high_byte_hold <= item.rx_byte;
    end
    if (take && cur_phase == PHASE_LOW) begin
      staged[cur_word] <= {high_byte_hold, item.rx_byte};
    end
  end

  `SFCP_ASSERT_NOW(a_phase_range, clk, rst, 1'b1, phase != 2'd3)
  `SFCP_ASSERT_NOW(a_word_range, clk, rst, 1'b1, word <= word_idx_t'(LAST_WORD))
  `SFCP_ASSERT_NOW(a_no_overwrite, clk, rst, out_valid && !out_ready, !(take && last))
  `SFCP_ASSERT_NEXT(a_result_follows, clk, rst, !rst && take && last, out_valid)
  `SFCP_ASSERT_NEXT(a_frame_rewinds, clk, rst, !rst && take && last,
                    phase == PHASE_HIGH && word == '0 && frame_good)

endmodule

### sv/sensor_frame_crc_parser.sv
// ----------------------------------------------------------------------------
// sensor_frame_crc_parser
// Parses the 27-byte measurement response, checks the CRC-8 of each of its
// nine words and publishes the cleaned values.
// ----------------------------------------------------------------------------
// One received byte is accepted per clock while the input does not stall;
// the CRC-8 byte step, word assembly and commit are combinational between
// the input register and the state/result registers. A result is offered
// in the cycle after the core takes the frame's last byte. Input stalls only
// when a frame's last byte arrives while the previous frame's result is still
// untaken. frame_start forces the byte to be frame byte 0 and drops any
// partial frame. A failed frame leaves the value outputs at the last good
// frame with crc_ok low; values are zero after reset.
// ----------------------------------------------------------------------------
module sensor_frame_crc_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         rx_byte,
  input  logic               frame_start,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               crc_ok,
  output logic [15:0]        pm1_0,
  output logic [15:0]        pm2_5,
  output logic [15:0]        pm4_0,
  output logic [15:0]        pm10_0,
  output logic signed [15:0] humidity,
  output logic signed [15:0] temperature,
  output logic signed [15:0] voc_index,
  output logic signed [15:0] nox_index,
  output logic [15:0]        formaldehyde
);
  import sfcp_pkg::*;

  item_t  item;
  logic   take;
  words_t committed;

  sfcp_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .frame_start(frame_start),
    .take       (take),
    .item       (item)
  );

  sfcp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .take      (take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .crc_ok    (crc_ok),
    .committed (committed)
  );

  assign pm1_0        = committed[0];
  assign pm2_5        = committed[1];
  assign pm4_0        = committed[2];
  assign pm10_0       = committed[3];
  assign humidity     = signed'(committed[4]);
  assign temperature  = signed'(committed[5]);
  assign voc_index    = signed'(committed[6]);
  assign nox_index    = signed'(committed[7]);
  assign formaldehyde = committed[8];

endmodule

### sim/sensor_frame_crc_parser_checker.sv
// ----------------------------------------------------------------------------
// Sensor frame CRC parser checker
// Watches both channels of the parser. Every accepted byte goes through a
// byte-level model of the frame parser. Each accepted result is compared,
// field by field, with the oldest predicted frame result.
// ----------------------------------------------------------------------------
package sfcp_tb_pkg;

  localparam int FRAME_LEN = 27;

  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] r;
    r = crc ^ data;
    repeat (8) r = r[7] ? ((r << 1) ^ sfcp_pkg::CRC_POLY) : (r << 1);
    return r;
  endfunction

endpackage

module sensor_frame_crc_parser_checker
  import sfcp_pkg::*;
  import sfcp_tb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [7:0]         rx_byte,
  input  logic               frame_start,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               crc_ok,
  input  logic [15:0]        pm1_0,
  input  logic [15:0]        pm2_5,
  input  logic [15:0]        pm4_0,
  input  logic [15:0]        pm10_0,
  input  logic signed [15:0] humidity,
  input  logic signed [15:0] temperature,
  input  logic signed [15:0] voc_index,
  input  logic signed [15:0] nox_index,
  input  logic [15:0]        formaldehyde,
  output int                 errors,
  output int                 outstanding
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic   ok;
    words_t vals;
  } frame_result_t;

  frame_result_t frame_results_q[$];

  logic [4:0]  byte_pos;
  logic [7:0]  crc_acc;
  logic [7:0]  hi_byte;
  logic        frame_ok;
  logic [15:0] staged [NUM_WORDS];
  words_t      committed;
  int          err_cnt = 0;

  string word_names [NUM_WORDS] = '{"pm1_0", "pm2_5", "pm4_0", "pm10_0", "humidity",
                                    "temperature", "voc_index", "nox_index",
                                    "formaldehyde"};

  task automatic parse_byte(input logic [7:0] b, input logic start);
    logic [1:0]  phase;
    int unsigned slot;
    logic [15:0] marker;
    if (start) begin
      byte_pos = '0;
      frame_ok = 1'b1;
      crc_acc  = CRC_INIT;
    end
    slot  = byte_pos / 3;
    phase = 2'(byte_pos % 5'd3);
    case (phase)
      PHASE_HIGH: begin
        hi_byte = b;
        crc_acc = crc8_next(CRC_INIT, b);
      end
      PHASE_LOW: begin
        crc_acc      = crc8_next(crc_acc, b);
        staged[slot] = {hi_byte, b};
      end
      default: begin
        if (crc_acc != b) frame_ok = 1'b0;
        crc_acc = CRC_INIT;
      end
    endcase
    if (byte_pos == FRAME_LEN - 1) begin
      if (frame_ok) begin
        for (int k = 0; k < NUM_WORDS; k++) begin
          marker = (k >= FIRST_SIGNED_WORD && k <= LAST_SIGNED_WORD) ?
                   SIGNED_INVALID : UNSIGNED_INVALID;
          committed[k] = (staged[k] == marker) ? 16'h0000 : staged[k];
        end
      end
      frame_results_q.push_back({frame_ok, committed});
      byte_pos = '0;
      frame_ok = 1'b1;
      crc_acc  = CRC_INIT;
    end else begin
      byte_pos = byte_pos + 5'd1;
    end
  endtask

  always @(posedge clk) begin
    frame_result_t want;
    words_t        seen;
    if (rst) begin
      byte_pos  = '0;
      crc_acc   = CRC_INIT;
      hi_byte   = '0;
      frame_ok  = 1'b1;
      committed = '0;
      frame_results_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        seen = {formaldehyde, nox_index, voc_index, temperature, humidity,
                pm10_0, pm4_0, pm2_5, pm1_0};
        if (frame_results_q.size() == 0) begin
          $error("result word with no frame result expected");
          err_cnt++;
        end else begin
          want = frame_results_q.pop_front();
          if (crc_ok !== want.ok) begin
            $error("crc_ok: expected %b, got %b", want.ok, crc_ok);
            err_cnt++;
          end
          for (int k = 0; k < NUM_WORDS; k++) begin
            if (seen[k] !== want.vals[k]) begin
              $error("%s: expected %h, got %h", word_names[k], want.vals[k], seen[k]);
              err_cnt++;
            end
          end
        end
      end
      if (in_valid && in_ready) parse_byte(rx_byte, frame_start);
    end
    errors      <= err_cnt;
    outstanding <= frame_results_q.size();
  end

endmodule

### sim/sensor_frame_crc_parser_tb.sv
// ----------------------------------------------------------------------------
// Sensor frame CRC parser testbench
// Drives received bytes into the parser: a few directed frames (value
// extremes, invalid markers, restarts, a failed CRC), then mostly well-formed
// frames with random content and occasional bad CRCs, mixed with truncated
// frames and noise. Both sides idle in random bursts; the checker predicts
// and compares every result.
// ----------------------------------------------------------------------------
module sensor_frame_crc_parser_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import sfcp_pkg::*;
  import sfcp_tb_pkg::*;

  localparam int TOTAL_ITEMS = 1550;
  localparam int QUIET_TAIL  = 200;
  localparam int SETTLE      = 12;
  localparam int CYCLE_LIMIT = 200000;

  typedef logic [15:0] frame_words_t [NUM_WORDS];

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         rx_byte = '0;
  logic               frame_start = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               crc_ok;
  logic [15:0]        pm1_0;
  logic [15:0]        pm2_5;
  logic [15:0]        pm4_0;
  logic [15:0]        pm10_0;
  logic signed [15:0] humidity;
  logic signed [15:0] temperature;
  logic signed [15:0] voc_index;
  logic signed [15:0] nox_index;
  logic [15:0]        formaldehyde;
  int                 errors;
  int                 outstanding;

  int sent = 0;
  int cycles = 0;
  int stall_left = 0;
  bit quiet = 1'b0;
  bit gaps_on = 1'b1;
  bit aligned = 1'b1;

  sensor_frame_crc_parser dut (.*);

  sensor_frame_crc_parser_checker chk (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst || quiet) begin
      stall_left <= 0;
      out_ready  <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= (stall_left == 1);
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 6);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic s);
    int gap;
    if (gaps_on && !quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    rx_byte     <= b;
    frame_start <= s;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic send_frame(input frame_words_t w, input bit start, input int bad_word,
                            input int cut);
    logic [7:0] bytes [FRAME_LEN];
    logic [7:0] crc;
    for (int k = 0; k < NUM_WORDS; k++) begin
      crc = crc8_next(crc8_next(CRC_INIT, w[k][15:8]), w[k][7:0]);
      if (k == bad_word) crc = crc ^ 8'($urandom_range(1, 255));
      bytes[3*k]   = w[k][15:8];
      bytes[3*k+1] = w[k][7:0];
      bytes[3*k+2] = crc;
    end
    for (int j = 0; j < cut; j++) send_byte(bytes[j], start && j == 0);
    aligned = (cut == FRAME_LEN);
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 11))
      0:       return UNSIGNED_INVALID;
      1:       return SIGNED_INVALID;
      2:       return 16'h0000;
      3:       return 16'h8000;
      4:       return 16'hFFFE;
      5:       return 16'h7FFE;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  initial begin
    frame_words_t w;
    int           mode;
    int           bad;
    int           n;
    bit           start;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int k = 0; k < 5; k++) send_byte(8'($urandom_range(0, 255)), k == 0);
    w = '{UNSIGNED_INVALID, 16'h0000, 16'hFFFE, 16'h0001, SIGNED_INVALID,
          16'h8000, 16'h7FFE, 16'hFFFF, UNSIGNED_INVALID};
    send_frame(w, 1'b1, -1, FRAME_LEN);
    for (int k = 0; k < NUM_WORDS; k++) w[k] = pick_word();
    send_frame(w, 1'b0, LAST_WORD, FRAME_LEN);
    w = '{SIGNED_INVALID, SIGNED_INVALID, SIGNED_INVALID, SIGNED_INVALID,
          UNSIGNED_INVALID, UNSIGNED_INVALID, UNSIGNED_INVALID, UNSIGNED_INVALID,
          SIGNED_INVALID};
    send_frame(w, 1'b1, -1, FRAME_LEN);
    wait_results();

    while (sent < TOTAL_ITEMS) begin
      if (sent >= TOTAL_ITEMS - QUIET_TAIL) quiet <= 1'b1;
      gaps_on = ($urandom_range(0, 2) != 0);
      for (int k = 0; k < NUM_WORDS; k++) w[k] = pick_word();
      start = aligned ? 1'($urandom_range(0, 1)) : 1'b1;
      bad   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, NUM_WORDS - 1) : -1;
      mode  = $urandom_range(0, 9);
      case (mode)
        7: send_frame(w, start, -1, $urandom_range(1, FRAME_LEN - 1));
        8: begin
          n = $urandom_range(1, 30);
          for (int k = 0; k < n; k++) begin
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 4) == 0);
          end
          aligned = 1'b0;
        end
        9: begin
          send_frame(w, start, bad, FRAME_LEN);
          if (!quiet) wait_results();
        end
        default: send_frame(w, start, bad, FRAME_LEN);
      endcase
    end

    wait_results();
    repeat (SETTLE) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/sfcp_pkg.sv
sv/sfcp_in_stage.sv
sv/sfcp_core.sv
sv/sensor_frame_crc_parser.sv
sim/sensor_frame_crc_parser_checker.sv
sim/sensor_frame_crc_parser_tb.sv
